/* rtl/core/mwmn_pkg.sv */
package mwmn_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WHEEL_W    = 32;
  localparam int GAIN_W     = 24;
  localparam int SPEED_W    = 31;
  localparam int RATE_W     = 16;
  localparam int NUM_WHEELS = 4;
  localparam int PROD_W     = GAIN_W + WHEEL_W;
  localparam int ROT_W      = PROD_W - FRAC_BITS;
  localparam int SUM_W      = ROT_W + 2;
  localparam int MAG_W      = WHEEL_W;
  localparam int REM_W      = MAG_W + 1;
  localparam int SCALE_W    = WHEEL_W + RATE_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SPEED_W;

  // default: two quotient bits per divider stage
  localparam int DIV_STEPS_DEF = 2;

  // 6.0 in Q16.16
  localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(393216);

  localparam int W_FL = 0;
  localparam int W_FR = 1;
  localparam int W_RR = 2;
  localparam int W_RL = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRONT_GAIN = 2'd0,
    CFG_REAR_GAIN  = 2'd1,
    CFG_MAX_SPEED  = 2'd2
  } cfg_idx_t;

  typedef logic signed [WHEEL_W-1:0] wheel_t;
  typedef wheel_t [NUM_WHEELS-1:0] wheel_vec_t;

  localparam wheel_t WHEEL_MAX = {1'b0, {(WHEEL_W-1){1'b1}}};
  localparam wheel_t WHEEL_MIN = {1'b1, {(WHEEL_W-1){1'b0}}};

  typedef struct packed {
    logic signed [WHEEL_W-1:0] forward_velocity;
    logic signed [WHEEL_W-1:0] lateral_velocity;
    logic signed [WHEEL_W-1:0] yaw_rate;
    logic                      raw_mode;
  } cmd_t;

  typedef struct packed {
    logic signed [WHEEL_W-1:0] wheel_front_left;
    logic signed [WHEEL_W-1:0] wheel_front_right;
    logic signed [WHEEL_W-1:0] wheel_rear_right;
    logic signed [WHEEL_W-1:0] wheel_rear_left;
    logic                      was_scaled;
    logic                      was_saturated;
  } wheel_res_t;

  typedef struct packed {
    wheel_vec_t w;
    logic       raw;
    logic       sat;
  } mix_out_t;

  typedef struct packed {
    wheel_vec_t         w;
    logic               raw;
    logic               sat;
    logic               scale;
    logic [MAG_W-1:0]   mag;
    logic [REM_W-1:0]   rem;
    logic [RATE_W-1:0]  quo;
  } div_word_t;

endpackage

/* rtl/core/mwmn_if.sv */
interface mwmn_cmd_if import mwmn_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface mwmn_wheel_if import mwmn_pkg::*; ();
  logic       valid;
  logic       ready;
  wheel_res_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/mwmn_mix.sv */
module mwmn_mix import mwmn_pkg::*; (
  input  logic                     clk,
  input  logic                     en_mul,
  input  logic                     en_sum,
  input  cmd_t                     cmd,
  input  logic signed [GAIN_W-1:0] front_gain,
  input  logic signed [GAIN_W-1:0] rear_gain,
  output mix_out_t                 mix
);

  logic signed [PROD_W-1:0]  prod_f_r;
  logic signed [PROD_W-1:0]  prod_b_r;
  logic signed [WHEEL_W-1:0] vx_r;
  logic signed [WHEEL_W-1:0] vy_r;
  logic                      raw_r;
  mix_out_t                  mix_r;

  logic signed [SUM_W-1:0] rot_f;
  logic signed [SUM_W-1:0] rot_b;
  logic signed [SUM_W-1:0] vx_e;
  logic signed [SUM_W-1:0] vy_e;
  logic signed [SUM_W-1:0] sum_c [NUM_WHEELS];
  mix_out_t                mix_nxt;

  // stage 1: rotation products, full precision
  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_f_r <= PROD_W'(front_gain) * PROD_W'(cmd.yaw_rate);
      prod_b_r <= PROD_W'(rear_gain) * PROD_W'(cmd.yaw_rate);
      vx_r     <= cmd.forward_velocity;
      vy_r     <= cmd.lateral_velocity;
      raw_r    <= cmd.raw_mode;
    end
  end

  // stage 2: floor shift, exact sums, clamp to int32
  always_comb begin
    rot_f = SUM_W'($signed(prod_f_r[PROD_W-1:FRAC_BITS]));
    rot_b = SUM_W'($signed(prod_b_r[PROD_W-1:FRAC_BITS]));
    vx_e  = SUM_W'(vx_r);
    vy_e  = SUM_W'(vy_r);
    sum_c[W_FL] = rot_f - vx_e - vy_e;
    sum_c[W_FR] = rot_f + vx_e - vy_e;
    sum_c[W_RR] = rot_b + vx_e + vy_e;
    sum_c[W_RL] = rot_b - vx_e + vy_e;
    mix_nxt.raw = raw_r;
    mix_nxt.sat = 1'b0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if ((&sum_c[i][SUM_W-1:WHEEL_W-1]) || !(|sum_c[i][SUM_W-1:WHEEL_W-1])) begin
        mix_nxt.w[i] = sum_c[i][WHEEL_W-1:0];
      end else begin
        mix_nxt.sat  = 1'b1;
        mix_nxt.w[i] = sum_c[i][SUM_W-1] ? WHEEL_MIN : WHEEL_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      mix_r <= mix_nxt;
    end
  end

  assign mix = mix_r;

endmodule

/* rtl/core/mwmn_peak.sv */
module mwmn_peak import mwmn_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  mix_out_t           mix,
  input  logic [SPEED_W-1:0] limit,
  output div_word_t          word
);

  logic [MAG_W-1:0] mag_c [NUM_WHEELS];
  logic [MAG_W-1:0] max_lo;
  logic [MAG_W-1:0] max_hi;
  logic [MAG_W-1:0] max_c;
  div_word_t        word_nxt;
  div_word_t        word_r;

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      mag_c[i] = mix.w[i][WHEEL_W-1] ? (~mix.w[i] + MAG_W'(1)) : mix.w[i];
    end
    max_lo = (mag_c[1] > mag_c[0]) ? mag_c[1] : mag_c[0];
    max_hi = (mag_c[3] > mag_c[2]) ? mag_c[3] : mag_c[2];
    max_c  = (max_hi > max_lo) ? max_hi : max_lo;

    word_nxt.w     = mix.w;
    word_nxt.raw   = mix.raw;
    word_nxt.sat   = mix.sat;
    word_nxt.scale = !mix.raw && (max_c > MAG_W'(limit));
    word_nxt.mag   = max_c;
    // limit < max when scaling, so the quotient fits RATE_W bits
    word_nxt.rem   = REM_W'(limit);
    word_nxt.quo   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word = word_r;

endmodule

/* rtl/core/mwmn_div.sv */
module mwmn_div import mwmn_pkg::*; #(
  parameter int unsigned STEPS  = DIV_STEPS_DEF,
  parameter int unsigned STAGES = RATE_W / STEPS
) (
  input  logic              clk,
  input  logic [STAGES-1:0] en,
  input  div_word_t         din,
  output div_word_t         dout
);

  div_word_t chain [STAGES+1];

  assign chain[0] = din;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    div_word_t step_nxt;
    div_word_t step_r;

    // restoring division, STEPS quotient bits per stage
    always_comb begin : step
      logic [REM_W-1:0] trial;
      step_nxt = chain[k];
      for (int j = 0; j < STEPS; j++) begin
        trial = {step_nxt.rem[REM_W-2:0], 1'b0};
        if (trial >= REM_W'(step_nxt.mag)) begin
          step_nxt.rem = trial - REM_W'(step_nxt.mag);
          step_nxt.quo = {step_nxt.quo[RATE_W-2:0], 1'b1};
        end else begin
          step_nxt.rem = trial;
          step_nxt.quo = {step_nxt.quo[RATE_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        step_r <= step_nxt;
      end
    end

    assign chain[k+1] = step_r;
  end

  assign dout = chain[STAGES];

endmodule

/* rtl/core/mwmn_scale.sv */
module mwmn_scale import mwmn_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  div_word_t  din,
  output wheel_res_t res
);

  localparam int RAW_W = WHEEL_W - FRAC_BITS + 1;

  logic signed [SCALE_W-1:0] rate_e;
  logic signed [SCALE_W-1:0] prod_c [NUM_WHEELS];
  logic signed [WHEEL_W:0]   trunc_c [NUM_WHEELS];
  wheel_vec_t                w_c;
  wheel_res_t                res_r;

  always_comb begin
    rate_e = SCALE_W'($signed({1'b0, din.quo}));
    for (int i = 0; i < NUM_WHEELS; i++) begin
      prod_c[i]  = SCALE_W'($signed(din.w[i])) * rate_e;
      // bias negatives so the shift rounds toward zero
      trunc_c[i] = {din.w[i][WHEEL_W-1], din.w[i]}
                 + (din.w[i][WHEEL_W-1] ? (WHEEL_W+1)'({FRAC_BITS{1'b1}})
                                        : (WHEEL_W+1)'(0));
      if (din.raw) begin
        w_c[i] = WHEEL_W'($signed(trunc_c[i][FRAC_BITS +: RAW_W]));
      end else if (din.scale) begin
        w_c[i] = prod_c[i][FRAC_BITS +: WHEEL_W];
      end else begin
        w_c[i] = din.w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.wheel_front_left  <= w_c[W_FL];
      res_r.wheel_front_right <= w_c[W_FR];
      res_r.wheel_rear_right  <= w_c[W_RR];
      res_r.wheel_rear_left   <= w_c[W_RL];
      res_r.was_scaled        <= din.scale;
      res_r.was_saturated     <= din.sat;
    end
  end

  assign res = res_r;

endmodule

/* rtl/core/mecanum_wheel_mix_normalize_core.sv */
// Channel     Port       Dir  Beat
// command     in_cmd     in   vx, vy, wz (Q16.16), raw_mode
// wheels      out_wheel  out  four wheel speeds, was_scaled, was_saturated
// config      cfg_*      in   one register write per cycle with cfg_wr_en
//
// One beat per cycle while out_wheel is not stalled.
// The depth is set by the restoring divider for the rate, DIV_STEPS_PER_STAGE
// quotient bits per stage, plus mix multiply, mix sum, peak and output stages.
// Reset clears the valid bits and loads the config registers; no sweep.
// A stage holds while the next one is full and stalled, so bubbles close up
// and in_cmd.ready stays high while any stage is empty.
module mecanum_wheel_mix_normalize_core import mwmn_pkg::*; #(
  parameter int unsigned DIV_STEPS_PER_STAGE = DIV_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mwmn_cmd_if.sink              in_cmd,
  mwmn_wheel_if.source          out_wheel,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned DIV_STAGES = RATE_W / DIV_STEPS_PER_STAGE;
  // mix multiply, mix sum, peak, divider stages, output
  localparam int unsigned N_STAGES   = DIV_STAGES + 4;
  localparam int unsigned DIV_FIRST  = 3;

  logic signed [GAIN_W-1:0] front_gain_r;
  logic signed [GAIN_W-1:0] rear_gain_r;
  logic [SPEED_W-1:0]       max_speed_r;

  logic [N_STAGES-1:0] valid_r;
  logic [N_STAGES-1:0] adv;

  mix_out_t   mix;
  div_word_t  peak_word;
  div_word_t  div_word;
  wheel_res_t res;

  // config registers; the user must write them only while the pipe is empty (not enforced by the block)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_gain_r <= '0;
      rear_gain_r  <= '0;
      max_speed_r  <= SPEED_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRONT_GAIN: front_gain_r <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_REAR_GAIN:  rear_gain_r  <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_MAX_SPEED:  max_speed_r  <= cfg_wdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or its contents move on
  always_comb begin
    adv[N_STAGES-1] = !valid_r[N_STAGES-1] || out_wheel.ready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) begin
        valid_r[0] <= in_cmd.valid;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (adv[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign in_cmd.ready = adv[0];

  mwmn_mix u_mix (
    .clk        (clk),
    .en_mul     (adv[0]),
    .en_sum     (adv[1]),
    .cmd        (in_cmd.data),
    .front_gain (front_gain_r),
    .rear_gain  (rear_gain_r),
    .mix        (mix)
  );

  mwmn_peak u_peak (
    .clk   (clk),
    .en    (adv[2]),
    .mix   (mix),
    .limit (max_speed_r),
    .word  (peak_word)
  );

  mwmn_div #(
    .STEPS  (DIV_STEPS_PER_STAGE),
    .STAGES (DIV_STAGES)
  ) u_div (
    .clk  (clk),
    .en   (adv[DIV_FIRST +: DIV_STAGES]),
    .din  (peak_word),
    .dout (div_word)
  );

  mwmn_scale u_scale (
    .clk (clk),
    .en  (adv[N_STAGES-1]),
    .din (div_word),
    .res (res)
  );

  assign out_wheel.valid = valid_r[N_STAGES-1];
  assign out_wheel.data  = res;

endmodule

/* tb/sv/mecanum_wheel_mix_normalize_checker.sv */
module mecanum_wheel_mix_normalize_checker import mwmn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mwmn_cmd_if                   cmd_mon,
  mwmn_wheel_if                 wheel_mon,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    outstanding,
  output int                    checked,
  output int                    scaled_seen,
  output int                    saturated_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UNIT   = longint'(1) << FRAC_BITS;
  localparam longint RAW_HI = 32767;
  localparam longint RAW_LO = -32768;
  localparam int     REPORT_MAX = 10;

  // register copies, loaded on the same edge as the block's
  logic signed [GAIN_W-1:0] front_gain;
  logic signed [GAIN_W-1:0] rear_gain;
  logic [SPEED_W-1:0]       speed_limit;

  wheel_res_t wheel_sets_due[$];
  int n_bad, n_checked, n_scaled, n_sat;

  function automatic longint clamp_to(input longint x, input longint lo, input longint hi,
                                      inout logic sat);
    if (x < lo) begin
      sat = 1'b1;
      return lo;
    end
    if (x > hi) begin
      sat = 1'b1;
      return hi;
    end
    return x;
  endfunction

  function automatic wheel_res_t mix_and_normalize(input cmd_t c);
    longint vx, vy, wz, rot_f, rot_r, mag, peak, lim, rate;
    longint w[NUM_WHEELS];
    logic sat;
    logic scaled;
    wheel_res_t r;
    vx = longint'($signed(c.forward_velocity));
    vy = longint'($signed(c.lateral_velocity));
    wz = longint'($signed(c.yaw_rate));
    rot_f = (longint'(front_gain) * wz) >>> FRAC_BITS;
    rot_r = (longint'(rear_gain) * wz) >>> FRAC_BITS;
    w[W_FL] = -vx - vy + rot_f;
    w[W_FR] =  vx - vy + rot_f;
    w[W_RR] =  vx + vy + rot_r;
    w[W_RL] = -vx + vy + rot_r;
    sat = 1'b0;
    scaled = 1'b0;
    for (int i = 0; i < NUM_WHEELS; i++)
      w[i] = clamp_to(w[i], longint'(WHEEL_MIN), longint'(WHEEL_MAX), sat);
    if (c.raw_mode) begin
      // integer division truncates toward zero
      for (int i = 0; i < NUM_WHEELS; i++)
        w[i] = clamp_to(w[i] / UNIT, RAW_LO, RAW_HI, sat);
    end else begin
      peak = 0;
      lim = longint'(speed_limit);
      for (int i = 0; i < NUM_WHEELS; i++) begin
        mag = (w[i] < 0) ? -w[i] : w[i];
        if (mag > peak) peak = mag;
      end
      if (peak > lim) begin
        rate = (lim << FRAC_BITS) / peak;
        scaled = 1'b1;
        for (int i = 0; i < NUM_WHEELS; i++)
          w[i] = (w[i] * rate) >>> FRAC_BITS;
      end
    end
    r.wheel_front_left  = wheel_t'(w[W_FL]);
    r.wheel_front_right = wheel_t'(w[W_FR]);
    r.wheel_rear_right  = wheel_t'(w[W_RR]);
    r.wheel_rear_left   = wheel_t'(w[W_RL]);
    r.was_scaled        = scaled;
    r.was_saturated     = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    wheel_res_t want;
    wheel_res_t got;
    if (!rst_n) begin
      front_gain  <= '0;
      rear_gain   <= '0;
      speed_limit <= SPEED_RESET;
      wheel_sets_due.delete();
      n_bad = 0;
      n_checked = 0;
      n_scaled = 0;
      n_sat = 0;
    end else begin
      if (cfg_wr_en === 1'b1) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FRONT_GAIN: front_gain  <= cfg_wdata[GAIN_W-1:0];
          CFG_REAR_GAIN:  rear_gain   <= cfg_wdata[GAIN_W-1:0];
          CFG_MAX_SPEED:  speed_limit <= cfg_wdata[SPEED_W-1:0];
          default: ;
        endcase
      end
      // result beat first: it always belongs to an older command
      if (wheel_mon.valid === 1'b1 && wheel_mon.ready === 1'b1) begin
        got = wheel_mon.data;
        if (wheel_sets_due.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_MAX)
            $display("[%0t] wheel beat with nothing outstanding: FL=%0d FR=%0d RR=%0d RL=%0d",
                     $realtime, got.wheel_front_left, got.wheel_front_right,
                     got.wheel_rear_right, got.wheel_rear_left);
        end else begin
          want = wheel_sets_due.pop_front();
          n_checked++;
          if (got.was_scaled === 1'b1) n_scaled++;
          if (got.was_saturated === 1'b1) n_sat++;
          if (got.wheel_front_left  !== want.wheel_front_left  ||
              got.wheel_front_right !== want.wheel_front_right ||
              got.wheel_rear_right  !== want.wheel_rear_right  ||
              got.wheel_rear_left   !== want.wheel_rear_left   ||
              got.was_scaled        !== want.was_scaled        ||
              got.was_saturated     !== want.was_saturated) begin
            n_bad++;
            if (n_bad <= REPORT_MAX) begin
              $display("[%0t] wheel set %0d differs", $realtime, n_checked);
              $display("  exp FL=%0d FR=%0d RR=%0d RL=%0d scaled=%0b sat=%0b",
                       want.wheel_front_left, want.wheel_front_right,
                       want.wheel_rear_right, want.wheel_rear_left,
                       want.was_scaled, want.was_saturated);
              $display("  got FL=%0d FR=%0d RR=%0d RL=%0d scaled=%0b sat=%0b",
                       got.wheel_front_left, got.wheel_front_right,
                       got.wheel_rear_right, got.wheel_rear_left,
                       got.was_scaled, got.was_saturated);
            end
          end
        end
      end
      if (cmd_mon.valid === 1'b1 && cmd_mon.ready === 1'b1)
        wheel_sets_due.push_back(mix_and_normalize(cmd_mon.data));
    end
    mismatches     <= n_bad;
    outstanding    <= wheel_sets_due.size();
    checked        <= n_checked;
    scaled_seen    <= n_scaled;
    saturated_seen <= n_sat;
  end

endmodule

/* tb/sv/mecanum_wheel_mix_normalize_core_test.sv */
module mecanum_wheel_mix_normalize_core_test import mwmn_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime CLK_PERIOD  = 8ns;
  localparam int      CYCLE_LIMIT = 400_000;
  localparam int      RAND_PHASES = 10;
  localparam int      PHASE_BEATS = 188;
  // pipeline is 12 deep by default; give it a margin at the tail
  localparam int      TAIL_CYCLES = 32;

  // handy Q16.16 values
  localparam logic signed [WHEEL_W-1:0] Q_ZERO   = 32'sh0000_0000;
  localparam logic signed [WHEEL_W-1:0] Q_ONE    = 32'sh0001_0000;
  localparam logic signed [WHEEL_W-1:0] Q_NEG1   = 32'shFFFF_0000;
  localparam logic signed [WHEEL_W-1:0] Q_HALF   = 32'sh0000_8000;
  localparam logic signed [WHEEL_W-1:0] Q_NHALF  = 32'shFFFF_8000;
  localparam logic signed [WHEEL_W-1:0] Q_QUART  = 32'sh0000_4000;
  localparam logic signed [WHEEL_W-1:0] Q_N1P5   = 32'shFFFE_8000;
  localparam logic signed [WHEEL_W-1:0] Q_TWO    = 32'sh0002_0000;
  localparam logic signed [WHEEL_W-1:0] Q_THREE  = 32'sh0003_0000;
  localparam logic signed [WHEEL_W-1:0] Q_SIX    = 32'sh0006_0000;
  localparam logic signed [WHEEL_W-1:0] Q_SIX_UP = 32'sh0006_0001;
  localparam logic signed [WHEEL_W-1:0] Q_20K    = 32'sh4E20_0000;
  localparam logic signed [WHEEL_W-1:0] Q_N20K   = 32'shB1E0_0000;

  localparam logic [GAIN_W-1:0]  GAIN_TOP    = 24'h7F_FFFF;
  localparam logic [GAIN_W-1:0]  GAIN_BOTTOM = 24'h80_0000;
  localparam logic [SPEED_W-1:0] SPEED_TOP   = 31'h7FFF_FFFF;

  logic clk;
  logic rst_n;
  logic                  cfg_wr_en;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mwmn_cmd_if   cmd_ch();
  mwmn_wheel_if wheel_ch();

  int mismatches, outstanding, checked, scaled_seen, saturated_seen;
  int beats_sent, directed_beats, settings_used;
  int cycle_count;
  int rx_tick;
  int rx_style;

  mecanum_wheel_mix_normalize_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (cmd_ch),
    .out_wheel (wheel_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // watches both channels and the register port, predicts and compares
  mecanum_wheel_mix_normalize_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_mon        (cmd_ch),
    .wheel_mon      (wheel_ch),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .checked        (checked),
    .scaled_seen    (scaled_seen),
    .saturated_seen (saturated_seen)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // hard stop in case the pipeline locks up
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d wheel sets still owed", cycle_count, outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: rx_tick picks a new style at random from this list.
  //   0 - always ready (no stalls at all)
  //   1 - coin toss per cycle
  //   2 - mostly stalled, ready one cycle in four on average
  //   3 - fixed rhythm on rx_tick, a run of ready then a shorter run of stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      wheel_ch.ready <= 1'b0;
      rx_tick = 0;
      rx_style = 0;
    end else begin
      if (rx_tick % 64 == 0) rx_style = $urandom_range(0, 3);
      case (rx_style)
        0:       wheel_ch.ready <= 1'b1;
        1:       wheel_ch.ready <= 1'($urandom_range(0, 1));
        2:       wheel_ch.ready <= ($urandom_range(0, 3) == 0);
        default: wheel_ch.ready <= ((rx_tick % 11) < 7);
      endcase
      rx_tick++;
    end
  end

  function automatic cmd_t make_cmd(input logic signed [WHEEL_W-1:0] vx,
                                    input logic signed [WHEEL_W-1:0] vy,
                                    input logic signed [WHEEL_W-1:0] wz,
                                    input logic raw);
    cmd_t c;
    c.forward_velocity = vx;
    c.lateral_velocity = vy;
    c.yaw_rate         = wz;
    c.raw_mode         = raw;
    return c;
  endfunction

  // speeds drawn from several magnitude bands so that both the unscaled
  // path and normalisation see plenty of traffic
  function automatic logic [WHEEL_W-1:0] rand_speed();
    logic [WHEEL_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 8 << FRAC_BITS);
      2: v = $urandom_range(0, 1 << 27);
      3: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          default: v = 32'h0001_0000;
        endcase
      end
      default: v = $urandom_range(0, 2 << FRAC_BITS);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    logic [GAIN_W-1:0] g;
    case ($urandom_range(0, 4))
      0: g = GAIN_TOP;
      1: g = GAIN_BOTTOM;
      2: g = GAIN_W'($urandom);
      default: begin
        g = GAIN_W'($urandom_range(0, 1 << 17));
        if ($urandom_range(0, 1) == 1) g = -g;
      end
    endcase
    return g;
  endfunction

  function automatic logic [SPEED_W-1:0] rand_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return SPEED_W'(1);
      2:       return SPEED_TOP;
      3:       return SPEED_W'($urandom);
      default: return SPEED_W'($urandom_range(0, 16 << FRAC_BITS));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    return make_cmd(rand_speed(), rand_speed(), rand_speed(), ($urandom_range(0, 9) < 3));
  endfunction

  // present one command beat and hold it until the block takes it
  task automatic send_cmd(input cmd_t c);
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    beats_sent++;
  endtask

  // sender gap; junk on the data lines while valid is low
  task automatic idle_sender(input int cycles);
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= rand_cmd();
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending and wait until every owed wheel set has come out
  task automatic drain_wheels();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // back-to-back writes of all three registers; only call when idle
  task automatic load_regs(input logic [GAIN_W-1:0] front, input logic [GAIN_W-1:0] rear,
                           input logic [SPEED_W-1:0] limit);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_FRONT_GAIN;
    cfg_wdata <= CFG_DATA_W'($signed(front));
    @(posedge clk);
    cfg_index <= CFG_REAR_GAIN;
    cfg_wdata <= CFG_DATA_W'($signed(rear));
    @(posedge clk);
    cfg_index <= CFG_MAX_SPEED;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int burst_left;
    int gap;
    logic [GAIN_W-1:0]  front, rear;
    logic [SPEED_W-1:0] limit;

    rst_n          = 1'b0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.data    = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_FRONT_GAIN;
    cfg_wdata      = '0;
    beats_sent     = 0;
    settings_used  = 1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed, reset registers: no rotation, limit 6.0 ---
    send_cmd(make_cmd(Q_ZERO, Q_ZERO, Q_ZERO, 1'b0));
    send_cmd(make_cmd(Q_SIX, Q_ZERO, Q_ONE, 1'b0));         // peak exactly on the limit
    send_cmd(make_cmd(Q_SIX_UP, Q_ZERO, Q_ZERO, 1'b0));     // one LSB over, normalised
    send_cmd(make_cmd(Q_THREE, Q_THREE, Q_ZERO, 1'b0));     // two axes sum to the limit
    send_cmd(make_cmd(WHEEL_MAX, WHEEL_MAX, Q_ZERO, 1'b0)); // sum overflow both ways
    send_cmd(make_cmd(WHEEL_MIN, WHEEL_MIN, Q_ZERO, 1'b0)); // sum overflow both ways
    send_cmd(make_cmd(WHEEL_MIN, Q_ZERO, Q_ZERO, 1'b0));    // negating the most negative
    send_cmd(make_cmd(Q_N1P5, Q_QUART, Q_ZERO, 1'b1));      // raw truncation toward zero
    send_cmd(make_cmd(Q_NHALF, Q_ZERO, Q_ZERO, 1'b1));      // raw, fraction drops to zero
    send_cmd(make_cmd(Q_20K, Q_20K, Q_ZERO, 1'b1));         // raw int16 clips high and low
    send_cmd(make_cmd(Q_N20K, Q_N20K, Q_ZERO, 1'b1));       // raw int16 clips low and high
    send_cmd(make_cmd(WHEEL_MAX, WHEEL_MAX, Q_ZERO, 1'b1)); // both clips at once
    drain_wheels();

    // --- extreme gains, widest limit: rotation overflow ---
    load_regs(GAIN_TOP, GAIN_BOTTOM, SPEED_TOP);
    send_cmd(make_cmd(Q_ZERO, Q_ZERO, WHEEL_MAX, 1'b0));
    send_cmd(make_cmd(Q_ZERO, Q_ZERO, WHEEL_MIN, 1'b0));
    send_cmd(make_cmd(Q_ONE, Q_NEG1, WHEEL_MIN, 1'b1));
    send_cmd(make_cmd(Q_ONE, Q_ZERO, Q_NEG1, 1'b0));
    drain_wheels();

    // --- zero limit: anything non-zero collapses to zero ---
    load_regs(GAIN_TOP, GAIN_BOTTOM, '0);
    send_cmd(make_cmd(Q_ZERO, Q_ZERO, Q_ZERO, 1'b0));
    send_cmd(make_cmd(32'sd1, Q_ZERO, Q_ZERO, 1'b0));
    send_cmd(make_cmd(WHEEL_MAX, Q_HALF, Q_NEG1, 1'b0));
    drain_wheels();

    // --- realistic gains of +/-0.75, limit of one LSB ---
    load_regs(24'h00_C000, 24'hFF_4000, SPEED_W'(1));
    send_cmd(make_cmd(Q_TWO, Q_NEG1, Q_HALF, 1'b0));
    send_cmd(make_cmd(Q_TWO, Q_NEG1, Q_HALF, 1'b1));
    directed_beats = beats_sent;

    // --- random phases, each under fresh register settings ---
    // Every phase boundary drains the pipe completely, so the sender
    // pauses until nothing is owed several times over.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain_wheels();
      case (phase)
        0: begin
          front = GAIN_BOTTOM;
          rear  = GAIN_TOP;
          limit = SPEED_TOP;
        end
        1: begin
          front = rand_gain();
          rear  = rand_gain();
          limit = '0;
        end
        default: begin
          front = rand_gain();
          rear  = rand_gain();
          limit = rand_limit();
        end
      endcase
      load_regs(front, rear, limit);
      burst_left = 0;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          // a quarter of bursts run straight on with no gap
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap != 0) idle_sender(gap);
        end
        send_cmd(rand_cmd());
        burst_left--;
      end
    end

    drain_wheels();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d command beats (%0d directed) over %0d register settings",
             beats_sent, directed_beats, settings_used);
    $display("%0d wheel sets compared, %0d normalised, %0d with saturation",
             checked, scaled_seen, saturated_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d wheel sets never arrived", mismatches, outstanding);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* mecanum_wheel_mix_normalize_core.f */
rtl/core/mwmn_pkg.sv
rtl/core/mwmn_if.sv
rtl/core/mwmn_mix.sv
rtl/core/mwmn_peak.sv
rtl/core/mwmn_div.sv
rtl/core/mwmn_scale.sv
rtl/core/mecanum_wheel_mix_normalize_core.sv
tb/sv/mecanum_wheel_mix_normalize_checker.sv
tb/sv/mecanum_wheel_mix_normalize_core_test.sv
